[src/prsd_pkg.sv]
// ----------------------------------------------------------------------------
// prsd_pkg
// Shared types and constants of the run-length pixel stream decoder.
// ----------------------------------------------------------------------------
package prsd_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT_CODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS  = 2'd2;
   localparam int CSR_DATA_W = 16;

   // Format code bits
   localparam int FMT_ALPHA_BIT = 0;
   localparam int FMT_RLE_BIT   = 1;

   // Header byte flag and pixel sizes
   localparam int RUN_FLAG_BIT = 7;
   localparam logic [2:0] RGB_BYTES  = 3'd3;
   localparam logic [2:0] RGBA_BYTES = 3'd4;

   // Reciprocal of 3 for values below 1024: q = (x * 683) >> 11
   localparam logic [19:0] DIV3_MUL   = 20'd683;
   localparam int          DIV3_SHIFT = 11;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_RUN     = 3'b010,
      PH_LITERAL = 3'b100
   } phase_type;

endpackage

[src/prsd_if.sv]
// ----------------------------------------------------------------------------
// prsd interfaces
// Valid/ready channels of the decoder: stream bytes in, writes out, and the
// register write port.
// ----------------------------------------------------------------------------
interface prsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface prsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_bytes;
   logic [2:0]  byte_count;
   logic [6:0]  repeat_count;
   logic        image_done;
   logic        corrupt;

   modport source (output valid, output pixel_bytes, output byte_count,
                   output repeat_count, output image_done, output corrupt,
                   input ready);
   modport sink   (input valid, input pixel_bytes, input byte_count,
                   input repeat_count, input image_done, input corrupt,
                   output ready);
endinterface

interface prsd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/pixel_rle_stream_decoder.sv]
// ----------------------------------------------------------------------------
// pixel_rle_stream_decoder
// Decodes a raw or run-length encoded 8-bit RGB/RGBA stream, one byte a beat,
// into image buffer writes of one to four bytes repeated up to 127 times.
// The block takes one stream byte per cycle while rsp ready is high: a byte
// is captured in an input register, decoded combinationally by the
// header/run/literal state machine and the remaining-byte counter, and any
// write it causes lands in an output register. A byte waits in the input
// register only while the output register holds a write that the sink has
// not yet taken. Run headers consume no output; the pixel that follows a run
// header gives one write beat for the whole run. Once the image is full,
// further bytes are accepted and dropped. A write to a defined register
// restarts decoding; the user must make writes only while the block is idle,
// and the block does not enforce this.
// ----------------------------------------------------------------------------
module pixel_rle_stream_decoder
   import prsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   prsd_req_if.sink      req_chan,
   prsd_rsp_if.source    rsp_chan,
   prsd_csr_if.sink      csr_chan
);

   // Configuration registers
   logic [1:0]            format_ff;
   logic [CSR_DATA_W-1:0] row_bytes_ff;
   logic [CSR_DATA_W-1:0] image_rows_ff;

   // Decoder state
   phase_type   phase_ff,        phase_in;
   logic [8:0]  literal_left_ff, literal_left_in;
   logic [6:0]  run_length_ff,   run_length_in;
   logic [23:0] gather_ff,       gather_in;
   logic [1:0]  gather_idx_ff,   gather_idx_in;
   logic [31:0] remaining_ff,    remaining_in;   // image bytes still unwritten
   logic        overran_ff,      overran_in;

   // Input register
   logic        in_valid_ff;
   logic [7:0]  byte_ff;

   // Output register
   logic        out_valid_ff;
   logic [31:0] out_bytes_ff,  out_bytes_in;
   logic [2:0]  out_count_ff,  out_count_in;
   logic [6:0]  out_rep_ff,    out_rep_in;
   logic        out_done_ff,   out_done_in;
   logic        out_corrupt_ff, out_corrupt_in;
   logic        emit;

   logic advance;
   logic csr_write;
   logic req_take;

   // Decode helpers
   logic [2:0]  bpp;
   logic        rem_small;
   logic [8:0]  rem_lo;
   logic [31:0] rem_dec;
   logic [8:0]  hdr_bytes;
   logic [8:0]  run_bytes;
   logic        hdr_cut;
   logic [19:0] div3_prod;
   logic [7:0]  rem_div;
   logic [31:0] gathered;

   // Image size for the restart value of the remaining counter
   logic [CSR_DATA_W-1:0] size_a, size_b;
   logic [31:0]           image_size;

   assign csr_write = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Drain the input register when the output register is free or emptying.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   // Product of the register set as it stands after this write.
   always_comb begin
      size_a = row_bytes_ff;
      size_b = image_rows_ff;
      if (csr_write && csr_chan.index == CSR_ROW_BYTES) begin
         size_a = csr_chan.data;
      end
      if (csr_write && csr_chan.index == CSR_IMAGE_ROWS) begin
         size_b = csr_chan.data;
      end
      image_size = 32'(size_a) * 32'(size_b);
   end

   assign bpp       = format_ff[FMT_ALPHA_BIT] ? RGBA_BYTES : RGB_BYTES;
   assign rem_small = (remaining_ff[31:9] == '0);
   assign rem_lo    = remaining_ff[8:0];
   assign rem_dec   = remaining_ff - 32'd1;

   // count * bytes-per-pixel for a 7-bit count, without a multiplier
   assign hdr_bytes = format_ff[FMT_ALPHA_BIT] ? {byte_ff[6:0], 2'b00}
                                               : ({1'b0, byte_ff[6:0], 1'b0}
                                                  + {2'b00, byte_ff[6:0]});
   assign run_bytes = format_ff[FMT_ALPHA_BIT] ? {run_length_ff, 2'b00}
                                               : ({1'b0, run_length_ff, 1'b0}
                                                  + {2'b00, run_length_ff});
   assign hdr_cut   = rem_small && (hdr_bytes > rem_lo);

   // Whole pixels that still fit: divide the small remainder by 3 or 4
   assign div3_prod = 20'(rem_lo) * DIV3_MUL;
   assign rem_div   = format_ff[FMT_ALPHA_BIT] ? {1'b0, rem_lo[8:2]}
                                               : div3_prod[DIV3_SHIFT+7:DIV3_SHIFT];

   // Complete pixel: gathered bytes plus the current one in the next slot
   always_comb begin
      case (gather_idx_ff)
         2'd0:    gathered = {24'd0, byte_ff};
         2'd1:    gathered = {16'd0, byte_ff, gather_ff[7:0]};
         2'd2:    gathered = {8'd0, byte_ff, gather_ff[15:0]};
         default: gathered = {byte_ff, gather_ff};
      endcase
   end

   // Decode of one stream byte
   always_comb begin
      phase_in        = phase_ff;
      literal_left_in = literal_left_ff;
      run_length_in   = run_length_ff;
      gather_in       = gather_ff;
      gather_idx_in   = gather_idx_ff;
      remaining_in    = remaining_ff;
      overran_in      = overran_ff;
      emit            = 1'b0;
      out_bytes_in    = {24'd0, byte_ff};
      out_count_in    = 3'd1;
      out_rep_in      = 7'd1;
      out_done_in     = 1'b0;
      out_corrupt_in  = 1'b0;

      if (remaining_ff == '0) begin
         // image full or empty: drop the byte
      end else if (!format_ff[FMT_RLE_BIT]) begin
         // raw pass-through
         remaining_in = rem_dec;
         emit         = 1'b1;
         out_done_in  = (remaining_ff == 32'd1);
      end else begin
         case (phase_ff)
            PH_RUN: begin
               if ({1'b0, gather_idx_ff} + 3'd1 < bpp) begin
                  // hold the byte until the pixel is complete
                  case (gather_idx_ff)
                     2'd0:    gather_in[7:0]   = byte_ff;
                     2'd1:    gather_in[15:8]  = byte_ff;
                     default: gather_in[23:16] = byte_ff;
                  endcase
                  gather_idx_in = gather_idx_ff + 2'd1;
               end else begin
                  phase_in      = PH_HEADER;
                  gather_in     = '0;
                  gather_idx_in = '0;
                  if (run_length_ff != '0) begin
                     remaining_in   = remaining_ff - 32'(run_bytes);
                     emit           = 1'b1;
                     out_bytes_in   = gathered;
                     out_count_in   = bpp;
                     out_rep_in     = run_length_ff;
                     out_done_in    = (remaining_ff == 32'(run_bytes));
                     out_corrupt_in = out_done_in && overran_ff;
                  end
               end
            end
            PH_LITERAL: begin
               remaining_in    = rem_dec;
               literal_left_in = literal_left_ff - 9'd1;
               if (literal_left_ff == 9'd1) begin
                  phase_in = PH_HEADER;
               end
               emit           = 1'b1;
               out_done_in    = (remaining_ff == 32'd1);
               out_corrupt_in = out_done_in && overran_ff;
            end
            default: begin
               // header byte; an unused phase code decodes as one too
               overran_in = hdr_cut;
               if (byte_ff[RUN_FLAG_BIT]) begin
                  run_length_in = hdr_cut ? rem_div[6:0] : byte_ff[6:0];
                  gather_in     = '0;
                  gather_idx_in = '0;
                  phase_in      = PH_RUN;
               end else begin
                  literal_left_in = hdr_cut ? rem_lo : hdr_bytes;
                  phase_in = (literal_left_in != '0) ? PH_LITERAL : PH_HEADER;
               end
            end
         endcase
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff     <= '0;
         row_bytes_ff  <= 16'd1;
         image_rows_ff <= 16'd1;
      end else if (csr_write) begin
         case (csr_chan.index)
            CSR_FORMAT_CODE: format_ff     <= csr_chan.data[1:0];
            CSR_ROW_BYTES:   row_bytes_ff  <= csr_chan.data;
            CSR_IMAGE_ROWS:  image_rows_ff <= csr_chan.data;
            default: ;  // no register: ignore
         endcase
      end
   end

   // Decoder state: a register write restarts decoding
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         literal_left_ff <= '0;
         run_length_ff   <= '0;
         gather_ff       <= '0;
         gather_idx_ff   <= '0;
         remaining_ff    <= 32'd1;
         overran_ff      <= 1'b0;
      end else if (csr_write && (csr_chan.index == CSR_FORMAT_CODE ||
                                 csr_chan.index == CSR_ROW_BYTES ||
                                 csr_chan.index == CSR_IMAGE_ROWS)) begin
         phase_ff        <= PH_HEADER;
         literal_left_ff <= '0;
         run_length_ff   <= '0;
         gather_ff       <= '0;
         gather_idx_ff   <= '0;
         remaining_ff    <= image_size;
         overran_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         literal_left_ff <= literal_left_in;
         run_length_ff   <= run_length_in;
         gather_ff       <= gather_in;
         gather_idx_ff   <= gather_idx_in;
         remaining_ff    <= remaining_in;
         overran_ff      <= overran_in;
      end
   end

   // Input register: take a beat whenever the slot is free or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_chan.stream_byte;
      end
   end

   // Output register: hold the write until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_bytes_ff   <= out_bytes_in;
         out_count_ff   <= out_count_in;
         out_rep_ff     <= out_rep_in;
         out_done_ff    <= out_done_in;
         out_corrupt_ff <= out_corrupt_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.pixel_bytes  = out_bytes_ff;
   assign rsp_chan.byte_count   = out_count_ff;
   assign rsp_chan.repeat_count = out_rep_ff;
   assign rsp_chan.image_done   = out_done_ff;
   assign rsp_chan.corrupt      = out_corrupt_ff;

endmodule
